>>> rtl/core/charge_level_display_filter_top_assert.svh
// Assertion macros used by the checker file.
`ifndef CHARGE_LEVEL_DISPLAY_FILTER_TOP_ASSERT_SVH
`define CHARGE_LEVEL_DISPLAY_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cldf_pkg.sv
`timescale 1ns / 1ps

package cldf_pkg;

    typedef enum logic [1:0] {
        ACT_INIT   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Normalized port status
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_IN   = 2'd1,
        ST_OUT  = 2'd2
    } status_t;

    localparam logic [7:0] RAW_ST_IN  = 8'd1;
    localparam logic [7:0] RAW_ST_OUT = 8'd2;
    localparam logic [6:0] BAT_MAX    = 7'd100;

    localparam int FIELD_PORTS = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_SNAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_SNAP   = 1'd1;
    localparam logic [6:0] BATTERY_SNAP_RST = 7'd5;
    localparam logic [7:0] POWER_SNAP_RST   = 8'd10;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] battery_raw;
        logic [7:0] port0_status;
        logic [7:0] port0_power;
        logic [7:0] port1_status;
        logic [7:0] port1_power;
        logic [7:0] port2_status;
        logic [7:0] port2_power;
    } raw_item_t;

    typedef struct packed {
        logic [6:0] battery_shown;
        logic [7:0] port0_shown;
        logic [7:0] port1_shown;
        logic [7:0] port2_shown;
        logic       charging;
    } disp_item_t;

    // One-hot-ish strobes for the item being retired this cycle
    typedef struct packed {
        logic init;
        logic sample;
        logic read;
    } lane_ctl_t;

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        abs_diff8 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> rtl/core/cldf_if.sv
`timescale 1ns / 1ps

interface cldf_raw_if;
    import cldf_pkg::*;
    logic      valid;
    logic      ready;
    raw_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cldf_disp_if;
    import cldf_pkg::*;
    logic       valid;
    logic       ready;
    disp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/cldf_window.sv
`timescale 1ns / 1ps

module cldf_window #(
    parameter int WINDOW_LEN = 5,
    parameter int DATA_W     = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fill,
    input  logic              push,
    input  logic [DATA_W-1:0] value,
    output logic [DATA_W-1:0] avg
);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW_LEN);
    localparam int RND_W  = SUM_W + 1;
    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SHIFT  = RND_W + $clog2(WINDOW_LEN);
    localparam int PROD_W = RND_W + SHIFT + 1;
    localparam int RECIP_INT = ((2 ** SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int HALF_INT  = WINDOW_LEN / 2;
    localparam logic [SHIFT:0]      RECIP = RECIP_INT[SHIFT:0];
    localparam logic [RND_W-1:0]    HALF  = HALF_INT[RND_W-1:0];
    localparam logic [SUM_W-1:0]    WLEN  = WINDOW_LEN[SUM_W-1:0];
    localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

    logic [DATA_W-1:0] win_reg [WINDOW_LEN];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [RND_W-1:0]  rnd;
    logic [PROD_W-1:0] prod;

    // Rounded mean via reciprocal multiply; exact for every reachable sum
    assign rnd  = {1'b0, sum_reg} + HALF;
    assign prod = {{(SHIFT + 1){1'b0}}, rnd} * {{RND_W{1'b0}}, RECIP};
    assign avg  = prod[SHIFT +: DATA_W];

    always_comb
    begin
        slot_next = slot_reg;
        sum_next  = sum_reg;
        if (fill)
        begin
            slot_next = '0;
            sum_next  = SUM_W'(value) * WLEN;
        end
        else if (push)
        begin
            slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
            sum_next  = sum_reg - SUM_W'(win_reg[slot_reg]) + SUM_W'(value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                if (fill || (push && (slot_reg == SLOT_W'(i))))
                begin
                    win_reg[i] <= value;
                end
            end
        end
    end

endmodule

>>> rtl/core/cldf_port_lane.sv
`timescale 1ns / 1ps

module cldf_port_lane #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cldf_pkg::lane_ctl_t ctl,
    input  logic [7:0]          status,
    input  logic [7:0]          power,
    input  logic [7:0]          snap,
    output logic [7:0]          avg
);
    import cldf_pkg::*;

    status_t    st;
    status_t    last_status_reg;
    logic [7:0] pw;
    logic       snap_hit;
    logic       fill;
    logic       push;

    always_comb
    begin
        if (status == RAW_ST_IN)
        begin
            st = ST_IN;
            pw = power;
        end
        else if (status == RAW_ST_OUT)
        begin
            st = ST_OUT;
            pw = power;
        end
        else
        begin
            st = ST_IDLE;
            pw = '0;
        end
    end

    // Refill on a status change or when the reading jumps away from the mean
    assign snap_hit = (st != last_status_reg) || (abs_diff8(pw, avg) >= snap);
    assign fill     = ctl.init || (ctl.sample && snap_hit);
    assign push     = ctl.sample && !snap_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_status_reg <= ST_IDLE;
        end
        else if (ctl.init || ctl.sample)
        begin
            last_status_reg <= st;
        end
    end

    cldf_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .DATA_W     (8)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .fill  (fill),
        .push  (push),
        .value (pw),
        .avg   (avg)
    );

endmodule

>>> rtl/core/cldf_battery_lane.sv
`timescale 1ns / 1ps

module cldf_battery_lane #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cldf_pkg::lane_ctl_t ctl,
    input  logic [7:0]          battery_raw,
    input  logic                charging,
    input  logic [6:0]          snap,
    output logic [6:0]          shown
);
    import cldf_pkg::*;

    logic [6:0] bat;
    logic [6:0] avg;
    logic [6:0] last_reg, last_next;
    logic       snap_hit;
    logic       fill;
    logic       push;

    assign bat      = (battery_raw > {1'b0, BAT_MAX}) ? BAT_MAX : battery_raw[6:0];
    assign snap_hit = abs_diff8({1'b0, bat}, {1'b0, last_reg}) >= {1'b0, snap};
    assign fill     = ctl.init || (ctl.sample && snap_hit);
    assign push     = ctl.sample && !snap_hit;

    // Against the last shown or refilled level: no drop while charging, no climb otherwise
    always_comb
    begin
        if (charging)
        begin
            shown = (avg < last_reg) ? last_reg : avg;
        end
        else
        begin
            shown = (avg > last_reg) ? last_reg : avg;
        end
    end

    always_comb
    begin
        last_next = last_reg;
        if (fill)
        begin
            last_next = bat;
        end
        else if (ctl.read)
        begin
            last_next = shown;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else
        begin
            last_reg <= last_next;
        end
    end

    cldf_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .DATA_W     (7)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .fill  (fill),
        .push  (push),
        .value (bat),
        .avg   (avg)
    );

endmodule

>>> rtl/core/charge_level_display_filter_top.sv
`timescale 1ns / 1ps
// Display filter for battery level and port power.
// raw: one beat per snapshot, with an action: init fills all windows, sample
//   pushes (or refills on a large jump), read returns the filtered values.
// disp: one beat per read; init and sample beats produce nothing.
// cfg: cfg_we/cfg_index/cfg_wdata write battery_snap (0) or power_snap (1);
//   write only while no beat is in flight.
// A read beat passes the input register, then the output register, to disp.
// Throughput: one raw beat per cycle unless a read waits on a stalled output;
//   retiring a beat from the input register is limited by the window average
//   path (sum register, constant-reciprocal multiply, snap compare).
// Reset: all windows, slots and history clear to zero, snaps go to 5 and 10;
//   the block accepts beats in the first cycle after reset.
// Stall: the output register holds a read result until taken; further init
//   and sample beats keep flowing, and only a second read waits in the input
//   register, which then deasserts raw.ready.
module charge_level_display_filter_top #(
    parameter int WINDOW_LEN = 5,
    parameter int PORT_COUNT = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cldf_raw_if.sink                          raw,
    cldf_disp_if.source                       disp,
    input  logic                              cfg_we,
    input  logic [cldf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cldf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import cldf_pkg::*;

    logic        stage_vld_reg, stage_vld_next;
    raw_item_t   stage_reg;
    logic        stage_fire;
    action_t     stage_act;
    lane_ctl_t   ctl;

    logic        out_vld_reg, out_vld_next;
    disp_item_t  out_reg, out_next;

    logic [6:0]  battery_snap_reg;
    logic [7:0]  power_snap_reg;

    logic [7:0]  f_status [FIELD_PORTS];
    logic [7:0]  f_power  [FIELD_PORTS];
    logic [7:0]  port_avg [PORT_COUNT];
    logic [7:0]  port_shown [FIELD_PORTS];
    logic        charging;
    logic [6:0]  battery_shown;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            battery_snap_reg <= BATTERY_SNAP_RST;
            power_snap_reg   <= POWER_SNAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BATTERY_SNAP: battery_snap_reg <= cfg_wdata[6:0];
                CFG_POWER_SNAP:   power_snap_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign stage_act = action_t'(stage_reg.action);

    // A read can only retire when the output register is free or draining
    assign stage_fire = stage_vld_reg &&
                        ((stage_act != ACT_READ) || !out_vld_reg || disp.ready);
    assign raw.ready  = !stage_vld_reg || stage_fire;

    always_comb
    begin
        ctl.init   = stage_fire && (stage_act == ACT_INIT);
        ctl.sample = stage_fire && (stage_act == ACT_SAMPLE);
        ctl.read   = stage_fire && (stage_act == ACT_READ);
    end

    assign stage_vld_next = raw.valid || (stage_vld_reg && !stage_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= raw.ready ? raw.valid : stage_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            stage_reg <= raw.data;
        end
    end

    assign f_status[0] = stage_reg.port0_status;
    assign f_status[1] = stage_reg.port1_status;
    assign f_status[2] = stage_reg.port2_status;
    assign f_power[0]  = stage_reg.port0_power;
    assign f_power[1]  = stage_reg.port1_power;
    assign f_power[2]  = stage_reg.port2_power;

    always_comb
    begin
        charging = 1'b0;
        for (int p = 0; p < FIELD_PORTS; p++)
        begin
            if (f_status[p] == RAW_ST_IN)
            begin
                charging = 1'b1;
            end
        end
    end

    cldf_battery_lane #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_battery (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .battery_raw (stage_reg.battery_raw),
        .charging    (charging),
        .snap        (battery_snap_reg),
        .shown       (battery_shown)
    );

    for (genvar p = 0; p < PORT_COUNT; p++)
    begin : g_port
        if (p < FIELD_PORTS)
        begin : g_field
            cldf_port_lane #(
                .WINDOW_LEN (WINDOW_LEN)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .status (f_status[p]),
                .power  (f_power[p]),
                .snap   (power_snap_reg),
                .avg    (port_avg[p])
            );
        end
        else
        begin : g_nofield
            // Ports past the input fields always sample as inactive
            cldf_port_lane #(
                .WINDOW_LEN (WINDOW_LEN)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .status (8'd0),
                .power  (8'd0),
                .snap   (power_snap_reg),
                .avg    (port_avg[p])
            );
        end
    end

    for (genvar p = 0; p < FIELD_PORTS; p++)
    begin : g_shown
        if (p < PORT_COUNT)
        begin : g_live
            assign port_shown[p] = port_avg[p];
        end
        else
        begin : g_absent
            assign port_shown[p] = '0;
        end
    end

    always_comb
    begin
        out_next.battery_shown = battery_shown;
        out_next.port0_shown   = port_shown[0];
        out_next.port1_shown   = port_shown[1];
        out_next.port2_shown   = port_shown[2];
        out_next.charging      = charging;
    end

    assign out_vld_next = ctl.read || (out_vld_reg && !disp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.read)
        begin
            out_reg <= out_next;
        end
    end

    assign disp.valid = out_vld_reg;
    assign disp.data  = out_reg;

endmodule

>>> rtl/core/cldf_checker.sv
`timescale 1ns / 1ps
`include "charge_level_display_filter_top_assert.svh"

module cldf_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 raw_valid,
    input logic                 raw_ready,
    input logic [1:0]           raw_action,
    input logic                 disp_valid,
    input logic                 disp_ready,
    input cldf_pkg::disp_item_t disp_data
);
    import cldf_pkg::*;

    `CLDF_ASSERT_NEXT(a_disp_hold, clk, rst_n, disp_valid && !disp_ready,
        disp_valid && $stable(disp_data), "disp beat dropped or changed while stalled")

    `CLDF_ASSERT_NOW(a_battery_range, clk, rst_n, disp_valid,
        disp_data.battery_shown <= BAT_MAX, "battery_shown above 100")

    // A fresh result must come from a read beat accepted on raw before it
    `CLDF_ASSERT_NOW(a_read_latency, clk, rst_n, $rose(disp_valid),
        $past(raw_valid && raw_ready && (raw_action == ACT_READ), 2),
        "result without a matching read beat")

    // Input backpressure only comes from a stalled output
    `CLDF_ASSERT_NOW(a_ready_cause, clk, rst_n, !raw_ready,
        disp_valid && !disp_ready, "raw.ready low without output stall")

endmodule

bind charge_level_display_filter_top cldf_checker u_cldf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .raw_valid  (raw.valid),
    .raw_ready  (raw.ready),
    .raw_action (raw.data.action),
    .disp_valid (disp.valid),
    .disp_ready (disp.ready),
    .disp_data  (disp.data)
);

>>> sim/charge_level_display_filter_top_tb.sv
`timescale 1ns / 1ps

module charge_level_display_filter_top_tb;
    import cldf_pkg::*;

    localparam int WIN             = 5;
    localparam int PORTS           = 3;
    localparam int CFG_SETTLE      = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int PHASES          = 6;
    localparam int BEATS_PER_PHASE = 140;

    typedef struct {
        raw_item_t  item;
        bit         typed;
        disp_item_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cldf_raw_if  raw_ch ();
    cldf_disp_if disp_ch ();

    charge_level_display_filter_top #(
        .WINDOW_LEN (WIN),
        .PORT_COUNT (PORTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw       (raw_ch),
        .disp      (disp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow of the filter state
    logic [6:0] bat_win [WIN];
    int         bat_slot;
    logic [6:0] bat_last;
    logic [7:0] pw_win [PORTS][WIN];
    int         pw_slot [PORTS];
    status_t    last_st [PORTS];
    logic [6:0] bat_snap;
    logic [7:0] pw_snap;

    disp_item_t reads_pending [$];
    stim_row_t  dir_rows [$];
    logic [7:0] port_mode [PORTS];

    bit no_idle;
    int errors;
    int quiet_cycles;
    int n_init, n_sample, n_read, n_none, n_checked, n_settings;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int bat_avg();
        int s;
        s = 0;
        for (int i = 0; i < WIN; i++)
            s += bat_win[i];
        return (s + WIN / 2) / WIN;
    endfunction

    function automatic int port_avg(input int p);
        int s;
        s = 0;
        for (int i = 0; i < WIN; i++)
            s += pw_win[p][i];
        return (s + WIN / 2) / WIN;
    endfunction

    function automatic int gap_of(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic status_t norm_status(input logic [7:0] s);
        if (s == RAW_ST_IN)
            return ST_IN;
        if (s == RAW_ST_OUT)
            return ST_OUT;
        return ST_IDLE;
    endfunction

    function automatic raw_item_t beat(input action_t a, input logic [7:0] b,
                                       input logic [7:0] s0, input logic [7:0] p0,
                                       input logic [7:0] s1, input logic [7:0] p1,
                                       input logic [7:0] s2, input logic [7:0] p2);
        return {a, b, s0, p0, s1, p1, s2, p2};
    endfunction

    task automatic snap_reset_state();
        bat_snap = BATTERY_SNAP_RST;
        pw_snap  = POWER_SNAP_RST;
        bat_slot = 0;
        bat_last = '0;
        for (int i = 0; i < WIN; i++)
            bat_win[i] = '0;
        for (int p = 0; p < PORTS; p++)
        begin
            pw_slot[p] = 0;
            last_st[p] = ST_IDLE;
            for (int i = 0; i < WIN; i++)
                pw_win[p][i] = '0;
        end
    endtask

    // Advances the shadow state by one beat; returns the display beat of a read.
    task automatic apply_beat(input raw_item_t it, output bit produces,
                              output disp_item_t shown);
        logic [6:0] bat;
        logic [7:0] st_raw [FIELD_PORTS];
        logic [7:0] pw_raw [FIELD_PORTS];
        status_t    st;
        logic [7:0] pw;
        int         a;
        bit         chg;
        produces = 1'b0;
        shown    = '0;
        bat = (it.battery_raw > BAT_MAX) ? BAT_MAX : it.battery_raw[6:0];
        st_raw[0] = it.port0_status;
        st_raw[1] = it.port1_status;
        st_raw[2] = it.port2_status;
        pw_raw[0] = it.port0_power;
        pw_raw[1] = it.port1_power;
        pw_raw[2] = it.port2_power;
        case (action_t'(it.action))
            ACT_INIT:
            begin
                for (int i = 0; i < WIN; i++)
                    bat_win[i] = bat;
                bat_slot = 0;
                bat_last = bat;
                for (int p = 0; p < PORTS; p++)
                begin
                    st = norm_status(st_raw[p]);
                    pw = (st == ST_IDLE) ? 8'd0 : pw_raw[p];
                    for (int i = 0; i < WIN; i++)
                        pw_win[p][i] = pw;
                    pw_slot[p] = 0;
                    last_st[p] = st;
                end
            end
            ACT_SAMPLE:
            begin
                if (gap_of(bat, bat_last) >= bat_snap)
                begin
                    for (int i = 0; i < WIN; i++)
                        bat_win[i] = bat;
                    bat_slot = 0;
                    bat_last = bat;
                end
                else
                begin
                    bat_win[bat_slot] = bat;
                    bat_slot = (bat_slot + 1 >= WIN) ? 0 : bat_slot + 1;
                end
                for (int p = 0; p < PORTS; p++)
                begin
                    st = norm_status(st_raw[p]);
                    pw = (st == ST_IDLE) ? 8'd0 : pw_raw[p];
                    if (st != last_st[p] || gap_of(pw, port_avg(p)) >= pw_snap)
                    begin
                        for (int i = 0; i < WIN; i++)
                            pw_win[p][i] = pw;
                        pw_slot[p] = 0;
                    end
                    else
                    begin
                        pw_win[p][pw_slot[p]] = pw;
                        pw_slot[p] = (pw_slot[p] + 1 >= WIN) ? 0 : pw_slot[p] + 1;
                    end
                    last_st[p] = st;
                end
            end
            ACT_READ:
            begin
                chg = 1'b0;
                for (int p = 0; p < FIELD_PORTS; p++)
                    if (st_raw[p] == RAW_ST_IN)
                        chg = 1'b1;
                a = bat_avg();
                // hold the level monotonic against the last shown value
                if (chg && a < bat_last)
                    a = bat_last;
                else if (!chg && a > bat_last)
                    a = bat_last;
                bat_last = a[6:0];
                produces = 1'b1;
                shown.battery_shown = a[6:0];
                shown.port0_shown   = 8'((PORTS > 0) ? port_avg(0) : 0);
                shown.port1_shown   = 8'((PORTS > 1) ? port_avg(1) : 0);
                shown.port2_shown   = 8'((PORTS > 2) ? port_avg(2) : 0);
                shown.charging      = chg;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("display beat %0d %s: got %0d, want %0d",
                                 n_checked, name, got, want));
    endtask

    task automatic send_beat(input raw_item_t it, input bit typed, input disp_item_t want);
        int         gap;
        bit         produces;
        disp_item_t shown;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            raw_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_ch.valid <= 1'b1;
        raw_ch.data  <= it;
        forever
        begin
            @(negedge clk);
            if (raw_ch.ready)
                break;
        end
        @(posedge clk);
        apply_beat(it, produces, shown);
        if (produces)
            reads_pending.push_back(typed ? want : shown);
        case (action_t'(it.action))
            ACT_INIT:   n_init++;
            ACT_SAMPLE: n_sample++;
            ACT_READ:   n_read++;
            default:    n_none++;
        endcase
    endtask

    // Call right after a beat was taken, with raw valid still high.
    task automatic go_idle_and_write(input logic [6:0] bs, input logic [7:0] ps);
        raw_ch.valid <= 1'b0;
        while (reads_pending.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BATTERY_SNAP;
        cfg_wdata <= {1'b0, bs};
        @(posedge clk);
        cfg_index <= CFG_POWER_SNAP;
        cfg_wdata <= ps;
        @(posedge clk);
        cfg_we <= 1'b0;
        bat_snap = bs;
        pw_snap  = ps;
        n_settings++;
    endtask

    task automatic make_beat(output raw_item_t it);
        int         r;
        int         span;
        int         v;
        action_t    act;
        logic [7:0] bat;
        logic [7:0] st [PORTS];
        logic [7:0] pw [PORTS];
        r = $urandom_range(0, 99);
        if (r < 4)
            act = ACT_INIT;
        else if (r < 8)
            act = ACT_NONE;
        else if (r < 60)
            act = ACT_SAMPLE;
        else
            act = ACT_READ;
        if ($urandom_range(0, 3) == 0)
            bat = 8'($urandom_range(0, 255));
        else
        begin
            // stay near the last level so that most samples are pushed
            span = int'(bat_snap) + 2;
            v = int'(bat_last) + int'($urandom_range(0, 2 * span)) - span;
            bat = (v < 0) ? 8'd0 : (v > 100) ? 8'd100 : v[7:0];
        end
        for (int p = 0; p < PORTS; p++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       port_mode[p] = 8'd0;
                    1:       port_mode[p] = RAW_ST_IN;
                    2:       port_mode[p] = RAW_ST_OUT;
                    default: port_mode[p] = 8'($urandom_range(0, 255));
                endcase
            end
            st[p] = port_mode[p];
            if ($urandom_range(0, 3) == 0)
                pw[p] = 8'($urandom_range(0, 255));
            else
            begin
                span = int'(pw_snap) + 2;
                v = port_avg(p) + int'($urandom_range(0, 2 * span)) - span;
                pw[p] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
            end
        end
        it = beat(act, bat, st[0], pw[0], st[1], pw[1], st[2], pw[2]);
    endtask

    task automatic add_row(input raw_item_t it, input bit typed, input disp_item_t want);
        stim_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic build_directed();
        // after reset: everything reads zero
        add_row(beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                {7'd0, 8'd0, 8'd0, 8'd0, 1'b0});
        add_row(beat(ACT_INIT, 8'd255, RAW_ST_IN, 8'd255, RAW_ST_OUT, 8'd0, 8'd3, 8'd200),
                1'b0, '0);
        add_row(beat(ACT_READ, 8'd0, RAW_ST_IN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                {7'd100, 8'd255, 8'd0, 8'd0, 1'b1});
        add_row(beat(ACT_SAMPLE, 8'd98, RAW_ST_IN, 8'd250, RAW_ST_OUT, 8'd5, 8'd0, 8'd77),
                1'b0, '0);
        add_row(beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        // every port changes status, battery jumps: all windows refill
        add_row(beat(ACT_SAMPLE, 8'd90, RAW_ST_OUT, 8'd100, 8'd255, 8'd9, RAW_ST_IN, 8'd255),
                1'b0, '0);
        add_row(beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, RAW_ST_IN, 8'd0), 1'b1,
                {7'd90, 8'd100, 8'd0, 8'd255, 1'b1});
        add_row(beat(ACT_NONE, 8'd33, RAW_ST_IN, 8'd12, RAW_ST_OUT, 8'd200, 8'd7, 8'd99),
                1'b0, '0);
        add_row(beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                {7'd90, 8'd100, 8'd0, 8'd255, 1'b0});
        add_row(beat(ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        add_row(beat(ACT_READ, 8'd0, 8'd0, 8'd0, RAW_ST_IN, 8'd0, 8'd0, 8'd0), 1'b1,
                {7'd0, 8'd0, 8'd0, 8'd0, 1'b1});
        // inactive ports read zero power whatever they carry
        add_row(beat(ACT_INIT, 8'd50, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
        add_row(beat(ACT_SAMPLE, 8'd54, 8'hFF, 8'hAA, 8'hFF, 8'hAA, 8'hFF, 8'hAA), 1'b0, '0);
        add_row(beat(ACT_SAMPLE, 8'd54, 8'hFF, 8'hAA, 8'hFF, 8'hAA, 8'hFF, 8'hAA), 1'b0, '0);
        add_row(beat(ACT_SAMPLE, 8'd54, 8'hFF, 8'hAA, 8'hFF, 8'hAA, 8'hFF, 8'hAA), 1'b0, '0);
        // average 52 over last 50: held down when idle, let up when charging
        add_row(beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                {7'd50, 8'd0, 8'd0, 8'd0, 1'b0});
        add_row(beat(ACT_READ, 8'd0, RAW_ST_IN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                {7'd52, 8'd0, 8'd0, 8'd0, 1'b1});
        add_row(beat(ACT_SAMPLE, 8'd200, RAW_ST_IN, 8'd0, RAW_ST_OUT, 8'd255, RAW_ST_IN, 8'd128),
                1'b0, '0);
        // port deviation one below and exactly at the snap threshold
        add_row(beat(ACT_SAMPLE, 8'd100, RAW_ST_IN, 8'd9, RAW_ST_OUT, 8'd245, RAW_ST_IN, 8'd137),
                1'b0, '0);
        add_row(beat(ACT_READ, 8'd0, RAW_ST_IN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
        add_row(beat(ACT_SAMPLE, 8'd101, 8'h81, 8'd50, RAW_ST_OUT, 8'd255, RAW_ST_OUT, 8'd0),
                1'b0, '0);
        add_row(beat(ACT_READ, 8'd0, RAW_ST_OUT, 8'd0, RAW_ST_OUT, 8'd0, RAW_ST_OUT, 8'd0),
                1'b0, '0);
    endtask

    // display side: random stalls, compare against the oldest pending read
    initial
    begin
        int         gap;
        disp_item_t got;
        disp_item_t want;
        disp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                disp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            disp_ch.ready <= 1'b1;
            forever
            begin
                @(negedge clk);
                if (disp_ch.valid && disp_ch.ready)
                    break;
            end
            got = disp_ch.data;
            @(posedge clk);
            if (reads_pending.size() == 0)
                flag_error("display beat with no read pending");
            else
            begin
                want = reads_pending.pop_front();
                check_field("battery_shown", {1'b0, got.battery_shown},
                            {1'b0, want.battery_shown});
                check_field("port0_shown", got.port0_shown, want.port0_shown);
                check_field("port1_shown", got.port1_shown, want.port1_shown);
                check_field("port2_shown", got.port2_shown, want.port2_shown);
                check_field("charging", {7'd0, got.charging}, {7'd0, want.charging});
            end
            n_checked++;
        end
    end

    always @(negedge clk)
    begin
        if ((raw_ch.valid && raw_ch.ready) || (disp_ch.valid && disp_ch.ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d reads outstanding",
                     quiet_cycles, reads_pending.size());
            $display("charge_level_display_filter_top_tb failed");
            $finish;
        end
    end

    initial
    begin
        raw_item_t  it;
        logic [6:0] bs;
        logic [7:0] ps;
        rst_n        <= 1'b0;
        raw_ch.valid <= 1'b0;
        raw_ch.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        errors       = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        for (int p = 0; p < PORTS; p++)
            port_mode[p] = 8'd0;
        snap_reset_state();
        build_directed();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin bs = 7'd0;   ps = 8'd0;   end
                1: begin bs = 7'd100; ps = 8'd255; end
                2: begin bs = 7'd1;   ps = 8'd1;   end
                5: begin bs = BATTERY_SNAP_RST; ps = POWER_SNAP_RST; end
                default:
                begin
                    bs = 7'($urandom_range(0, 100));
                    ps = 8'($urandom_range(0, 255));
                end
            endcase
            go_idle_and_write(bs, ps);
            no_idle = (ph % 2 == 1);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 29) == 0)
                    no_idle = ~no_idle;
                make_beat(it);
                send_beat(it, 1'b0, '0);
            end
        end

        raw_ch.valid <= 1'b0;
        while (reads_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Raw beats: %0d init, %0d sample, %0d read, %0d unused action",
                 n_init, n_sample, n_read, n_none);
        $display("Display beats checked: %0d over %0d snap settings plus reset values",
                 n_checked, n_settings);
        if (errors == 0)
            $display("charge_level_display_filter_top_tb passed");
        else
            $display("charge_level_display_filter_top_tb failed");
        $finish;
    end

endmodule
